@@ hw/rtl/bsa_pkg.sv @@
// Package for the deadlock-avoidance allocator: sizes, status codes, operation codes.
// Used by bankers_safety_allocator; no dependencies.
`default_nettype none
package bsa_pkg;
   localparam int NUM_PROC = 8;
   localparam int NUM_RES  = 4;
   localparam int PW       = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
   localparam int ROW_W    = 8 * NUM_RES;
   localparam int WORK_W   = 12;

   typedef enum logic [1:0] {
      OP_CLAIM = 2'd0,
      OP_ALLOC = 2'd1,
      OP_AVAIL = 2'd2,
      OP_REQ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_CLAIM    = 3'd1,
      ST_NOTAVAIL = 3'd2,
      ST_UNSAFE   = 3'd3,
      ST_LOADED   = 3'd4,
      ST_BADPROC  = 3'd5
   } status_type;

   localparam logic [4:0] ACTIVE_RESET = 5'd8;
endpackage
`default_nettype wire

@@ hw/rtl/bankers_safety_allocator.sv @@
// Deadlock-avoidance allocator (Banker's algorithm), top level.
// Depends on bsa_pkg.
//
// Claim and allocation rows live in two memories with a registered read, one row of all
// resources per entry; a valid flag per row makes rows that were never loaded read
// as zero after reset. Row loads and "set available" pass through the read and done
// states. A request reads its process's rows, checks claim then availability
// per resource in index order, writes the tentative allocation, then runs the
// safety scan: one process row read per step, each tested row passing through a
// read state and a test state. An unsafe result goes through a roll-back state that
// writes the allocation row back. One word is handled at a time; a finished result
// moves to an output register, so the next word may be accepted and processed while
// it waits. A word that finishes while the previous result is still waiting holds in
// its last state.
`default_nettype none
module bankers_safety_allocator
   import bsa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [3:0] req_process,
   input  wire logic [7:0] req_amount_0,
   input  wire logic [7:0] req_amount_1,
   input  wire logic [7:0] req_amount_2,
   input  wire logic [7:0] req_amount_3,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RD    = 7'b0000010,
      S_CHK   = 7'b0000100,
      S_SRD   = 7'b0001000,
      S_STEST = 7'b0010000,
      S_ROLL  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] active_ff;

   // Row memories.
   logic [ROW_W-1:0] claim_mem [NUM_PROC];
   logic [ROW_W-1:0] alloc_mem [NUM_PROC];
   logic [ROW_W-1:0] claim_q, alloc_q;
   logic [PW-1:0]    rd_addr;
   logic             c_we, a_we;
   logic [PW-1:0]    wr_addr;
   logic [ROW_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (c_we) claim_mem[wr_addr] <= wr_data;
      if (a_we) alloc_mem[wr_addr] <= wr_data;
      claim_q <= claim_mem[rd_addr];
      alloc_q <= alloc_mem[rd_addr];
   end

   // Row valid flags: a row never written since reset reads as zero.
   logic [NUM_PROC-1:0] c_ok_ff, a_ok_ff;
   logic                c_ok_q, a_ok_q;
   logic [ROW_W-1:0]    claim_row, alloc_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ok_ff <= '0;
         a_ok_ff <= '0;
      end else begin
         if (c_we) c_ok_ff[wr_addr] <= 1'b1;
         if (a_we) a_ok_ff[wr_addr] <= 1'b1;
      end
      c_ok_q <= c_ok_ff[rd_addr];
      a_ok_q <= a_ok_ff[rd_addr];
   end

   assign claim_row = c_ok_q ? claim_q : '0;
   assign alloc_row = a_ok_q ? alloc_q : '0;

   // Held request word.
   logic [1:0]       op_ff;
   logic [3:0]       proc_ff;
   logic [ROW_W-1:0] amt_ff;
   logic [7:0]       avail_ff [NUM_RES];
   logic [WORK_W-1:0] work_ff [NUM_RES];
   logic [NUM_PROC-1:0] fin_ff;
   logic [PW-1:0]    scan_ff;
   logic [4:0]       done_ff;
   logic             moved_ff;
   logic [ROW_W-1:0] oldalloc_ff;
   logic [2:0]       stat_ff;
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [4:0]       live;
   logic [ROW_W-1:0] amt_in_w;
   logic             rsp_free;

   assign live = (active_ff > 5'(NUM_PROC)) ? 5'(NUM_PROC) : active_ff;
   assign amt_in_w = ROW_W'({req_amount_3, req_amount_2, req_amount_1, req_amount_0});
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // Request check over resources in order.
   logic [2:0] chk_status;
   logic       fits;
   always_comb begin
      logic signed [9:0] need;
      chk_status = ST_GRANTED;
      fits = 1'b1;
      for (int r = NUM_RES - 1; r >= 0; r--) begin
         need = $signed({2'b00, claim_row[8*r +: 8]}) - $signed({2'b00, alloc_row[8*r +: 8]});
         if ($signed({2'b00, amt_ff[8*r +: 8]}) > need) chk_status = ST_CLAIM;
         else if (amt_ff[8*r +: 8] > avail_ff[r]) chk_status = ST_NOTAVAIL;
         if ((need > 0) && (WORK_W'(need) > work_ff[r])) fits = 1'b0;
      end
   end

   // Next scan index with wrap at the live count.
   logic          scan_last;
   assign scan_last = ({1'b0, scan_ff} + 5'd1) >= live;

   always_comb begin
      state_in = state_ff;
      rd_addr = proc_ff[PW-1:0];
      c_we = 1'b0;
      a_we = 1'b0;
      wr_addr = proc_ff[PW-1:0];
      wr_data = amt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) state_in = S_RD;
            rd_addr = req_process[PW-1:0];
         end
         S_RD: begin
            state_in = (op_ff == OP_REQ) ? S_CHK : S_DONE;
            if (32'(proc_ff) < NUM_PROC) begin
               c_we = (op_ff == OP_CLAIM);
               a_we = (op_ff == OP_ALLOC);
            end
         end
         S_CHK: begin
            rd_addr = '0;
            state_in = S_DONE;
            if ((stat_ff != ST_BADPROC) && (chk_status == ST_GRANTED)) begin
               a_we = 1'b1;
               for (int r = 0; r < NUM_RES; r++)
                  wr_data[8*r +: 8] = alloc_row[8*r +: 8] + amt_ff[8*r +: 8];
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            rd_addr = scan_ff;
            state_in = S_STEST;
         end
         S_STEST: begin
            rd_addr = scan_ff;
            state_in = S_SRD;
            if (!fin_ff[scan_ff] && fits) begin
               if (done_ff + 5'd1 >= live) state_in = S_DONE;
            end else if (scan_last && !moved_ff) begin
               state_in = S_ROLL;
            end
         end
         S_ROLL: begin
            a_we = 1'b1;
            wr_data = oldalloc_ff;
            state_in = S_DONE;
         end
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= ACTIVE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_RES; r++) avail_ff[r] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) active_ff <= csr_write_data;

         // Output register: load a finished word once the slot is free.
         if ((state_ff == S_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_status_ff <= stat_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               op_ff <= req_operation;
               proc_ff <= req_process;
               amt_ff <= amt_in_w;
            end
            S_RD: begin
               stat_ff <= ST_LOADED;
               unique case (op_ff)
                  OP_AVAIL:
                     for (int r = 0; r < NUM_RES; r++) avail_ff[r] <= amt_ff[8*r +: 8];
                  OP_REQ:
                     if ({1'b0, proc_ff} >= live) stat_ff <= ST_BADPROC;
                  default:
                     if (32'(proc_ff) >= NUM_PROC) stat_ff <= ST_BADPROC;
               endcase
            end
            S_CHK: begin
               oldalloc_ff <= alloc_row;
               fin_ff <= '0;
               scan_ff <= '0;
               done_ff <= '0;
               moved_ff <= 1'b0;
               // A bad process skips the check and keeps its status.
               if (stat_ff != ST_BADPROC) begin
                  stat_ff <= chk_status;
                  if (chk_status == ST_GRANTED) begin
                     for (int r = 0; r < NUM_RES; r++) begin
                        avail_ff[r] <= avail_ff[r] - amt_ff[8*r +: 8];
                        work_ff[r] <= WORK_W'(avail_ff[r] - amt_ff[8*r +: 8]);
                     end
                  end
               end
            end
            S_STEST: begin
               if (!fin_ff[scan_ff] && fits) begin
                  fin_ff[scan_ff] <= 1'b1;
                  done_ff <= done_ff + 5'd1;
                  for (int r = 0; r < NUM_RES; r++)
                     work_ff[r] <= work_ff[r] + WORK_W'(alloc_row[8*r +: 8]);
                  // Restart from the lowest process after each release.
                  scan_ff <= '0;
                  moved_ff <= 1'b0;
               end else begin
                  scan_ff <= scan_last ? '0 : PW'({1'b0, scan_ff} + 5'd1);
                  if (scan_last) moved_ff <= 1'b0;
               end
            end
            S_ROLL: begin
               stat_ff <= ST_UNSAFE;
               for (int r = 0; r < NUM_RES; r++)
                  avail_ff[r] <= avail_ff[r] + amt_ff[8*r +: 8];
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ tb/tb_bankers_safety_allocator.sv @@
// Self-checking testbench for bankers_safety_allocator: drives row loads, available
// updates and resource requests, predicts each status word and compares in order.
// Depends on bsa_pkg and the bankers_safety_allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_bankers_safety_allocator
   import bsa_pkg::*;
;

   typedef struct packed {
      op_type     op;
      logic [3:0] proc_id;
      logic [7:0] amt0, amt1, amt2, amt3;
   } alloc_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = 5'd0;
   logic       req_valid = 1'b0;
   wire        req_ready;
   logic [1:0] req_operation = 2'd0;
   logic [3:0] req_process = 4'd0;
   logic [7:0] req_amount_0 = 8'd0, req_amount_1 = 8'd0;
   logic [7:0] req_amount_2 = 8'd0, req_amount_3 = 8'd0;
   wire        rsp_valid;
   logic       rsp_ready = 1'b0;
   wire  [2:0] rsp_status;

   bankers_safety_allocator uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_process(req_process),
      .req_amount_0(req_amount_0), .req_amount_1(req_amount_1),
      .req_amount_2(req_amount_2), .req_amount_3(req_amount_3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   // Predictor state.
   logic [7:0] claim_rows [NUM_PROC][NUM_RES];
   logic [7:0] alloc_rows [NUM_PROC][NUM_RES];
   logic [7:0] avail_vec [NUM_RES];
   logic [4:0] live_setting = ACTIVE_RESET;

   alloc_word_type pending_words[$];
   status_type  expected_status[$];
   int          error_count = 0;
   bit          quiet_mode = 1'b0;
   bit          hold_rsp = 1'b0;
   int          send_gap = 0;
   int          take_gap = 0;
   int          stall_cycles = 0;
   int          last_accept_age = 0;

   function automatic int live_procs();
      return (live_setting > NUM_PROC) ? NUM_PROC : int'(live_setting);
   endfunction

   // Safety scan: repeatedly release the lowest unfinished process whose need fits.
   function automatic bit state_is_safe();
      int  n;
      int  done;
      int  work [NUM_RES];
      bit  fin [NUM_PROC];
      bit  moved;
      bit  fits;
      n = live_procs();
      done = 0;
      for (int r = 0; r < NUM_RES; r++) work[r] = avail_vec[r];
      for (int p = 0; p < NUM_PROC; p++) fin[p] = 1'b0;
      while (done < n) begin
         moved = 1'b0;
         for (int p = 0; p < n && !moved; p++) begin
            if (!fin[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NUM_RES; r++)
                  if (int'(claim_rows[p][r]) - int'(alloc_rows[p][r]) > work[r]) fits = 1'b0;
               if (fits) begin
                  for (int r = 0; r < NUM_RES; r++)
                     work[r] = (work[r] + alloc_rows[p][r]) & 12'hFFF;
                  fin[p] = 1'b1;
                  done++;
                  moved = 1'b1;
               end
            end
         end
         if (!moved) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic status_type predict_status(alloc_word_type w);
      logic [7:0] amt [NUM_RES];
      int         p;
      int         need;
      amt[0] = w.amt0; amt[1] = w.amt1; amt[2] = w.amt2; amt[3] = w.amt3;
      p = w.proc_id;
      case (w.op)
         OP_CLAIM, OP_ALLOC: begin
            if (p >= NUM_PROC) return ST_BADPROC;
            for (int r = 0; r < NUM_RES; r++)
               if (w.op == OP_CLAIM) claim_rows[p][r] = amt[r];
               else alloc_rows[p][r] = amt[r];
            return ST_LOADED;
         end
         OP_AVAIL: begin
            for (int r = 0; r < NUM_RES; r++) avail_vec[r] = amt[r];
            return ST_LOADED;
         end
         default: begin
            if (p >= live_procs()) return ST_BADPROC;
            for (int r = 0; r < NUM_RES; r++) begin
               need = int'(claim_rows[p][r]) - int'(alloc_rows[p][r]);
               if (int'(amt[r]) > need) return ST_CLAIM;
               if (amt[r] > avail_vec[r]) return ST_NOTAVAIL;
            end
            for (int r = 0; r < NUM_RES; r++) begin
               avail_vec[r] = avail_vec[r] - amt[r];
               alloc_rows[p][r] = alloc_rows[p][r] + amt[r];
            end
            if (state_is_safe()) return ST_GRANTED;
            for (int r = 0; r < NUM_RES; r++) begin
               avail_vec[r] = avail_vec[r] + amt[r];
               alloc_rows[p][r] = alloc_rows[p][r] - amt[r];
            end
            return ST_UNSAFE;
         end
      endcase
   endfunction

   function automatic alloc_word_type make_word(op_type op, int p, int a0, int a1, int a2,
                                                int a3);
      alloc_word_type w;
      w.op = op; w.proc_id = p[3:0];
      w.amt0 = a0[7:0]; w.amt1 = a1[7:0]; w.amt2 = a2[7:0]; w.amt3 = a3[7:0];
      return w;
   endfunction

   // Random word: mostly small counts so requests often get through to the scan.
   function automatic alloc_word_type random_word();
      alloc_word_type w;
      int          sel;
      int          big;
      sel = $urandom_range(0, 99);
      big = ($urandom_range(0, 9) == 0) ? 255 : 12;
      w.proc_id = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, NUM_PROC - 1));
      w.op = (sel < 20) ? OP_CLAIM : (sel < 35) ? OP_ALLOC : (sel < 45) ? OP_AVAIL : OP_REQ;
      if (w.op == OP_AVAIL) big = big * 3;
      if (big > 255) big = 255;
      w.amt0 = 8'($urandom_range(0, big)); w.amt1 = 8'($urandom_range(0, big));
      w.amt2 = 8'($urandom_range(0, big)); w.amt3 = 8'($urandom_range(0, big));
      if (w.op == OP_REQ && $urandom_range(0, 2) != 0) begin
         w.amt0 = w.amt0 >> 2; w.amt1 = w.amt1 >> 2;
         w.amt2 = w.amt2 >> 2; w.amt3 = w.amt3 >> 2;
      end
      return w;
   endfunction

   // Driver: presents queued words, inserting short random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // Hold the word until accepted.
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0 && !(req_valid && req_ready
                                                 && pending_words.size() == 0)) begin
         if (!quiet_mode && !(req_valid && req_ready) && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else begin
            req_valid     <= 1'b1;
            req_operation <= pending_words[0].op;
            req_process   <= pending_words[0].proc_id;
            req_amount_0  <= pending_words[0].amt0;
            req_amount_1  <= pending_words[0].amt1;
            req_amount_2  <= pending_words[0].amt2;
            req_amount_3  <= pending_words[0].amt3;
            expected_status.push_back(predict_status(pending_words.pop_front()));
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random short stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_ready <= 1'b0;
         stall_cycles <= stall_cycles + 1;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         take_gap <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: compares each accepted status word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            $display("%0t: unexpected status word %0d", $time, rsp_status);
            error_count++;
         end else begin
            if (rsp_status !== expected_status[0]) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        expected_status[0], rsp_status);
               error_count++;
            end
            void'(expected_status.pop_front());
         end
      end
   end

   // Watchdog on cycles with no accepted word on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_rsp)
         last_accept_age <= 0;
      else
         last_accept_age <= last_accept_age + 1;
      if (last_accept_age > 5000) begin
         $display("bankers_safety_allocator: mismatch");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_status.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_active(int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[4:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      live_setting = value[4:0];
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_words.push_back(random_word());
   endtask

   initial begin
      for (int p = 0; p < NUM_PROC; p++)
         for (int r = 0; r < NUM_RES; r++) begin
            claim_rows[p][r] = 8'd0;
            alloc_rows[p][r] = 8'd0;
         end
      for (int r = 0; r < NUM_RES; r++) avail_vec[r] = 8'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero request on empty state, extremes, bad processes.
      pending_words.push_back(make_word(OP_REQ, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_CLAIM, 0, 255, 255, 255, 255));
      pending_words.push_back(make_word(OP_CLAIM, 15, 1, 2, 3, 4));
      pending_words.push_back(make_word(OP_ALLOC, 8, 1, 2, 3, 4));
      pending_words.push_back(make_word(OP_ALLOC, 1, 9, 0, 0, 0));
      pending_words.push_back(make_word(OP_AVAIL, 15, 255, 255, 255, 255));
      pending_words.push_back(make_word(OP_REQ, 0, 255, 255, 255, 255));
      pending_words.push_back(make_word(OP_REQ, 0, 0, 0, 0, 1));
      pending_words.push_back(make_word(OP_AVAIL, 0, 1, 0, 0, 0));
      pending_words.push_back(make_word(OP_REQ, 0, 1, 1, 0, 0));
      pending_words.push_back(make_word(OP_REQ, 0, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_CLAIM, 2, 200, 0, 0, 0));
      pending_words.push_back(make_word(OP_AVAIL, 0, 100, 255, 255, 255));
      pending_words.push_back(make_word(OP_REQ, 0, 100, 0, 0, 0));
      pending_words.push_back(make_word(OP_REQ, 2, 1, 0, 0, 0));
      pending_words.push_back(make_word(OP_REQ, 9, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_REQ, 7, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_CLAIM, 2, 0, 0, 0, 0));
      pending_words.push_back(make_word(OP_REQ, 0, 170, 85, 0, 0));
      wait_drained();

      // Active count settings: extremes, zero and above the table size.
      write_active(1);
      pending_words.push_back(make_word(OP_REQ, 1, 0, 0, 0, 0));
      queue_random(80);
      wait_drained();
      write_active(0);
      pending_words.push_back(make_word(OP_REQ, 0, 0, 0, 0, 0));
      queue_random(20);
      wait_drained();
      write_active(31);
      queue_random(150);
      // Long receiver hold-off while the sender keeps offering words.
      hold_rsp = 1'b1;
      while (stall_cycles < 400) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();
      write_active(16);
      queue_random(150);
      wait_drained();
      write_active(3);
      queue_random(150);
      wait_drained();
      write_active(8);
      queue_random(150);
      wait_drained();
      // Final stretch without idling.
      quiet_mode = 1'b1;
      queue_random(100);
      wait_drained();

      if (error_count == 0)
         $display("bankers_safety_allocator: match");
      else
         $display("bankers_safety_allocator: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
